// ===== rtl/core/gtp_pkg.sv =====
// shared constants, types and helper functions for the gimbal target point core
package gtp_pkg;

    localparam int COORD_WIDTH    = 32;
    localparam int ANGLE_WIDTH    = 16;
    localparam int TRIG_FRAC_BITS = 18;
    localparam int DIST_WIDTH     = COORD_WIDTH - 1;

    // angle units: 1/64 degree
    localparam int FULL_TURN     = 23040;
    localparam int THREE_QUARTER = 17280;
    localparam int HALF_TURN     = 11520;
    localparam int QUARTER_TURN  = 5760;
    localparam int EIGHTH_TURN   = 2880;

    localparam int TURN_WIDTH = $clog2(FULL_TURN);
    localparam int FRAC_WIDTH = $clog2(QUARTER_TURN);
    localparam int BASE_WIDTH = $clog2(EIGHTH_TURN + 1);
    localparam int WRAP_WIDTH = $clog2((1 << ANGLE_WIDTH) + FULL_TURN);
    localparam int WRAP_TURNS = ((1 << (ANGLE_WIDTH - 1)) + FULL_TURN - 1) / FULL_TURN;
    localparam longint WRAP_RECIP = (longint'(1) << WRAP_WIDTH) / FULL_TURN;

    // pi / 11520 in Q40
    localparam longint RAD_Q40   = 299845282;
    localparam int     RAD_WIDTH = 29;
    localparam int     RAD_SHIFT = 10;

    localparam int Q30_WIDTH  = 30;
    localparam int TERM_WIDTH = 31;
    localparam int ACC_WIDTH  = 32;
    localparam int DIV_SHIFT  = 31;
    localparam longint ONE_Q30 = longint'(1) << 30;

    localparam int TAY_STEPS  = 5;
    localparam int NUM_ANGLES = 5;
    localparam logic [2:0] TAY_LAST = 3'd5;

    localparam int SC_WIDTH    = TRIG_FRAC_BITS + 2;
    localparam int DIR_WIDTH   = TRIG_FRAC_BITS + 3;
    localparam int PROD_WIDTH  = SC_WIDTH + DIR_WIDTH;
    localparam int RSUM_WIDTH  = PROD_WIDTH + 1;
    localparam int TRIG_SHIFT  = 30 - TRIG_FRAC_BITS;
    localparam longint TRIG_HALF = (TRIG_SHIFT > 0) ? (longint'(1) << (TRIG_SHIFT - 1)) : 0;
    localparam longint DIR_HALF  = longint'(1) << (TRIG_FRAC_BITS - 1);
    localparam longint DIR_ONE   = longint'(1) << TRIG_FRAC_BITS;

    // offset scaling
    localparam int MUL_WIDTH  = DIR_WIDTH + DIST_WIDTH;
    localparam int MAG_WIDTH  = MUL_WIDTH + 1 - TRIG_FRAC_BITS;
    localparam int OSUM_WIDTH = ((MAG_WIDTH + 1 > COORD_WIDTH) ? MAG_WIDTH + 1 : COORD_WIDTH) + 1;
    localparam longint COORD_MAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) << (COORD_WIDTH - 1));

    // pipeline depths
    localparam int PREP_LAT   = 5;
    localparam int CELL_LAT   = 3;
    localparam int SCALE_LAT  = 2;
    localparam int PASS_DEPTH = PREP_LAT + TAY_STEPS * CELL_LAT + NUM_ANGLES * CELL_LAT;
    localparam int TOTAL_LAT  = PASS_DEPTH + SCALE_LAT;

    // stream packing
    localparam int IN_TDATA_WIDTH =
        ((DIST_WIDTH + 3 * COORD_WIDTH + 5 * ANGLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_WIDTH = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OFS_DIST   = 0;
    localparam int OFS_ORG    = DIST_WIDTH;
    localparam int OFS_ROLL   = DIST_WIDTH + 3 * COORD_WIDTH;
    localparam int OFS_PITCH  = OFS_ROLL + ANGLE_WIDTH;
    localparam int OFS_YAW    = OFS_PITCH + ANGLE_WIDTH;
    localparam int OFS_CPITCH = OFS_YAW + ANGLE_WIDTH;
    localparam int OFS_CYAW   = OFS_CPITCH + ANGLE_WIDTH;

    // rotation lanes in order of application
    localparam logic [2:0] LANE_CAM_PITCH  = 3'd0;
    localparam logic [2:0] LANE_CAM_YAW    = 3'd1;
    localparam logic [2:0] LANE_BODY_ROLL  = 3'd2;
    localparam logic [2:0] LANE_BODY_PITCH = 3'd3;
    localparam logic [2:0] LANE_BODY_YAW   = 3'd4;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // taylor divisors and their Q31 reciprocals
    localparam longint SIN_RCP_1 = (longint'(1) << DIV_SHIFT) / 6;
    localparam longint SIN_RCP_2 = (longint'(1) << DIV_SHIFT) / 20;
    localparam longint SIN_RCP_3 = (longint'(1) << DIV_SHIFT) / 42;
    localparam longint SIN_RCP_4 = (longint'(1) << DIV_SHIFT) / 72;
    localparam longint SIN_RCP_5 = (longint'(1) << DIV_SHIFT) / 110;
    localparam longint COS_RCP_1 = (longint'(1) << DIV_SHIFT) / 2;
    localparam longint COS_RCP_2 = (longint'(1) << DIV_SHIFT) / 12;
    localparam longint COS_RCP_3 = (longint'(1) << DIV_SHIFT) / 30;
    localparam longint COS_RCP_4 = (longint'(1) << DIV_SHIFT) / 56;
    localparam longint COS_RCP_5 = (longint'(1) << DIV_SHIFT) / 90;

    typedef struct packed {
        logic [Q30_WIDTH-1:0]         x2;
        logic [TERM_WIDTH-1:0]        sterm;
        logic [TERM_WIDTH-1:0]        cterm;
        logic signed [ACC_WIDTH-1:0]  s;
        logic signed [ACC_WIDTH-1:0]  c;
        logic [1:0]                   quad;
        logic                         swap;
    } t_tay;

    typedef struct packed {
        logic signed [ACC_WIDTH-1:0]  s;
        logic signed [ACC_WIDTH-1:0]  c;
        logic [1:0]                   quad;
        logic                         swap;
    } t_lane;

    typedef struct packed {
        t_lane [NUM_ANGLES-1:0]           lane;
        logic [2:0][DIR_WIDTH-1:0]        dir;
    } t_rot_bus;

    typedef struct packed {
        logic [DIST_WIDTH-1:0]            rng;
        logic [2:0][COORD_WIDTH-1:0]      org;
    } t_pass;

    function automatic logic [6:0] sin_div(input logic [2:0] step);
        logic [6:0] d;
        case (step)
            3'd1:    d = 7'd6;
            3'd2:    d = 7'd20;
            3'd3:    d = 7'd42;
            3'd4:    d = 7'd72;
            default: d = 7'd110;
        endcase
        return d;
    endfunction

    function automatic logic [6:0] cos_div(input logic [2:0] step);
        logic [6:0] d;
        case (step)
            3'd1:    d = 7'd2;
            3'd2:    d = 7'd12;
            3'd3:    d = 7'd30;
            3'd4:    d = 7'd56;
            default: d = 7'd90;
        endcase
        return d;
    endfunction

    function automatic logic [TERM_WIDTH-1:0] sin_rcp(input logic [2:0] step);
        logic [TERM_WIDTH-1:0] r;
        case (step)
            3'd1:    r = TERM_WIDTH'(SIN_RCP_1);
            3'd2:    r = TERM_WIDTH'(SIN_RCP_2);
            3'd3:    r = TERM_WIDTH'(SIN_RCP_3);
            3'd4:    r = TERM_WIDTH'(SIN_RCP_4);
            default: r = TERM_WIDTH'(SIN_RCP_5);
        endcase
        return r;
    endfunction

    function automatic logic [TERM_WIDTH-1:0] cos_rcp(input logic [2:0] step);
        logic [TERM_WIDTH-1:0] r;
        case (step)
            3'd1:    r = TERM_WIDTH'(COS_RCP_1);
            3'd2:    r = TERM_WIDTH'(COS_RCP_2);
            3'd3:    r = TERM_WIDTH'(COS_RCP_3);
            3'd4:    r = TERM_WIDTH'(COS_RCP_4);
            default: r = TERM_WIDTH'(COS_RCP_5);
        endcase
        return r;
    endfunction

    // first component of the rotated pair
    function automatic logic [1:0] pair_a(input logic [2:0] lane);
        logic [1:0] a;
        case (lane)
            LANE_CAM_PITCH, LANE_BODY_PITCH: a = AXIS_Z;
            LANE_BODY_ROLL:                  a = AXIS_Y;
            default:                         a = AXIS_X;
        endcase
        return a;
    endfunction

    // second component of the rotated pair
    function automatic logic [1:0] pair_b(input logic [2:0] lane);
        logic [1:0] b;
        case (lane)
            LANE_CAM_PITCH, LANE_BODY_PITCH: b = AXIS_X;
            LANE_BODY_ROLL:                  b = AXIS_Z;
            default:                         b = AXIS_Y;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/gtp_angle_prep.sv =====
// angle wrap, octant fold and radian conversion ahead of the taylor cells
module gtp_angle_prep import gtp_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle,
    output t_tay                          o_tay
);

    logic [WRAP_WIDTH-1:0]           n_u;
    logic [2*WRAP_WIDTH-1:0]         n_prod;
    logic [WRAP_WIDTH-1:0]           r_u, r_qe;
    logic [WRAP_WIDTH-1:0]           n_rem;
    logic [TURN_WIDTH-1:0]           n_m, r_m;
    logic [1:0]                      n_quad, r_quad3, r_quad4, r_quad5;
    logic [FRAC_WIDTH-1:0]           n_f;
    logic                            n_swap, r_swap3, r_swap4, r_swap5;
    logic [BASE_WIDTH-1:0]           n_t, r_t;
    logic [BASE_WIDTH+RAD_WIDTH-1:0] n_xp;
    logic [Q30_WIDTH-1:0]            r_x4, r_x5, r_x2;
    logic [2*Q30_WIDTH-1:0]          n_sq;

    // stage 1: shift positive, estimate turn count
    always_comb begin
        n_u    = WRAP_WIDTH'(int'(i_angle) + WRAP_TURNS * FULL_TURN);
        n_prod = {WRAP_WIDTH'(0), n_u} * {WRAP_WIDTH'(0), WRAP_WIDTH'(WRAP_RECIP)};
    end

    // stage 2: exact remainder
    always_comb begin
        n_rem = r_u - WRAP_WIDTH'(r_qe * WRAP_WIDTH'(FULL_TURN));
        n_m   = (n_rem >= WRAP_WIDTH'(FULL_TURN)) ? TURN_WIDTH'(n_rem - WRAP_WIDTH'(FULL_TURN))
                                                  : TURN_WIDTH'(n_rem);
    end

    // stage 3: quadrant and fold into the first octant
    always_comb begin
        if (r_m >= TURN_WIDTH'(THREE_QUARTER)) begin
            n_quad = QUAD_3;
            n_f    = FRAC_WIDTH'(r_m - TURN_WIDTH'(THREE_QUARTER));
        end else if (r_m >= TURN_WIDTH'(HALF_TURN)) begin
            n_quad = QUAD_2;
            n_f    = FRAC_WIDTH'(r_m - TURN_WIDTH'(HALF_TURN));
        end else if (r_m >= TURN_WIDTH'(QUARTER_TURN)) begin
            n_quad = QUAD_1;
            n_f    = FRAC_WIDTH'(r_m - TURN_WIDTH'(QUARTER_TURN));
        end else begin
            n_quad = QUAD_0;
            n_f    = FRAC_WIDTH'(r_m);
        end
        n_swap = (n_f > FRAC_WIDTH'(EIGHTH_TURN));
        n_t    = n_swap ? BASE_WIDTH'(FRAC_WIDTH'(QUARTER_TURN) - n_f) : BASE_WIDTH'(n_f);
    end

    // stages 4 and 5: radians in Q30, then the rounded square
    always_comb begin
        n_xp = ({RAD_WIDTH'(0), r_t} * {BASE_WIDTH'(0), RAD_WIDTH'(RAD_Q40)})
             + (BASE_WIDTH+RAD_WIDTH)'(512);
        n_sq = ({Q30_WIDTH'(0), r_x4} * {Q30_WIDTH'(0), r_x4})
             + (2*Q30_WIDTH)'(longint'(1) << 29);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u     <= n_u;
            r_qe    <= n_prod[2*WRAP_WIDTH-1:WRAP_WIDTH];
            r_m     <= n_m;
            r_quad3 <= n_quad;
            r_swap3 <= n_swap;
            r_t     <= n_t;
            r_quad4 <= r_quad3;
            r_swap4 <= r_swap3;
            r_x4    <= n_xp[RAD_SHIFT +: Q30_WIDTH];
            r_quad5 <= r_quad4;
            r_swap5 <= r_swap4;
            r_x5    <= r_x4;
            r_x2    <= n_sq[30 +: Q30_WIDTH];
        end
    end

    always_comb begin
        o_tay.x2    = r_x2;
        o_tay.sterm = TERM_WIDTH'(r_x5);
        o_tay.cterm = TERM_WIDTH'(ONE_Q30);
        o_tay.s     = $signed(ACC_WIDTH'(r_x5));
        o_tay.c     = $signed(ACC_WIDTH'(ONE_Q30));
        o_tay.quad  = r_quad5;
        o_tay.swap  = r_swap5;
    end

endmodule

// ===== rtl/core/gtp_tay_cell.sv =====
// one taylor step for sine and cosine: multiply by x^2, divide by constant, accumulate
module gtp_tay_cell import gtp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [2:0] i_step,
    input  t_tay       i_tay,
    output t_tay       o_tay
);

    logic [TERM_WIDTH+Q30_WIDTH-1:0] n_sp, n_cp;
    logic [2*TERM_WIDTH-1:0]         n_sq, n_cq;
    logic [TERM_WIDTH-1:0]           r1_sv, r1_cv, r2_sv, r2_cv, r2_sq, r2_cq;
    logic [TERM_WIDTH-1:0]           n_srem, n_crem, n_sterm, n_cterm;
    logic [TERM_WIDTH-1:0]           w_sdiv, w_cdiv;
    t_tay                            r1_tay, r2_tay, r3_tay, n_tay;
    logic                            w_sub, w_sin_on;

    assign w_sdiv   = TERM_WIDTH'(sin_div(i_step));
    assign w_cdiv   = TERM_WIDTH'(cos_div(i_step));
    assign w_sub    = i_step[0];
    assign w_sin_on = (i_step != TAY_LAST);

    always_comb begin
        n_sp = {Q30_WIDTH'(0), i_tay.sterm} * {TERM_WIDTH'(0), i_tay.x2};
        n_cp = {Q30_WIDTH'(0), i_tay.cterm} * {TERM_WIDTH'(0), i_tay.x2};
        n_sq = {TERM_WIDTH'(0), r1_sv} * {TERM_WIDTH'(0), sin_rcp(i_step)};
        n_cq = {TERM_WIDTH'(0), r1_cv} * {TERM_WIDTH'(0), cos_rcp(i_step)};
    end

    // quotient estimate is exact or one low
    always_comb begin
        n_srem  = r2_sv - TERM_WIDTH'(r2_sq * w_sdiv);
        n_crem  = r2_cv - TERM_WIDTH'(r2_cq * w_cdiv);
        n_sterm = (n_srem >= w_sdiv) ? r2_sq + TERM_WIDTH'(1) : r2_sq;
        n_cterm = (n_crem >= w_cdiv) ? r2_cq + TERM_WIDTH'(1) : r2_cq;
        n_tay       = r2_tay;
        n_tay.sterm = n_sterm;
        n_tay.cterm = n_cterm;
        if (w_sin_on) begin
            n_tay.s = w_sub ? r2_tay.s - $signed(ACC_WIDTH'(n_sterm))
                            : r2_tay.s + $signed(ACC_WIDTH'(n_sterm));
        end
        n_tay.c = w_sub ? r2_tay.c - $signed(ACC_WIDTH'(n_cterm))
                        : r2_tay.c + $signed(ACC_WIDTH'(n_cterm));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sv  <= n_sp[30 +: TERM_WIDTH];
            r1_cv  <= n_cp[30 +: TERM_WIDTH];
            r1_tay <= i_tay;
            r2_sv  <= r1_sv;
            r2_cv  <= r1_cv;
            r2_sq  <= n_sq[DIV_SHIFT +: TERM_WIDTH];
            r2_cq  <= n_cq[DIV_SHIFT +: TERM_WIDTH];
            r2_tay <= r1_tay;
            r3_tay <= n_tay;
        end
    end

    assign o_tay = r3_tay;

endmodule

// ===== rtl/core/gtp_rot_cell.sv =====
// one plane rotation of the direction vector by the sine and cosine of its lane
module gtp_rot_cell import gtp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [2:0] i_lane,
    input  t_rot_bus   i_bus,
    output t_rot_bus   o_bus
);

    t_lane                          w_lane;
    logic signed [ACC_WIDTH-1:0]    w_s0, w_c0;
    logic signed [ACC_WIDTH:0]      n_ms, n_mc;
    logic signed [SC_WIDTH-1:0]     r1_s, r1_c;
    logic signed [DIR_WIDTH-1:0]    w_a, w_b;
    logic signed [PROD_WIDTH-1:0]   n_ca, n_sb, n_sa, n_cb;
    logic signed [PROD_WIDTH-1:0]   r2_ca, r2_sb, r2_sa, r2_cb;
    logic signed [RSUM_WIDTH-1:0]   n_ra, n_rb;
    logic [1:0]                     w_ia, w_ib;
    t_rot_bus                       r1_bus, r2_bus, r3_bus, n_bus;

    assign w_lane = i_bus.lane[i_lane];
    assign w_ia   = pair_a(i_lane);
    assign w_ib   = pair_b(i_lane);

    // undo the octant fold, then the quadrant
    always_comb begin
        w_s0 = w_lane.swap ? w_lane.c : w_lane.s;
        w_c0 = w_lane.swap ? w_lane.s : w_lane.c;
        unique case (w_lane.quad)
            QUAD_0: begin n_ms =  w_s0; n_mc =  w_c0; end
            QUAD_1: begin n_ms =  w_c0; n_mc = -w_s0; end
            QUAD_2: begin n_ms = -w_s0; n_mc = -w_c0; end
            default: begin n_ms = -w_c0; n_mc =  w_s0; end
        endcase
        n_ms = (n_ms + (ACC_WIDTH+1)'(TRIG_HALF)) >>> TRIG_SHIFT;
        n_mc = (n_mc + (ACC_WIDTH+1)'(TRIG_HALF)) >>> TRIG_SHIFT;
    end

    always_comb begin
        w_a  = $signed(r1_bus.dir[w_ia]);
        w_b  = $signed(r1_bus.dir[w_ib]);
        n_ca = r1_c * w_a;
        n_sb = r1_s * w_b;
        n_sa = r1_s * w_a;
        n_cb = r1_c * w_b;
    end

    always_comb begin
        n_ra = (RSUM_WIDTH'(r2_ca) - RSUM_WIDTH'(r2_sb) + RSUM_WIDTH'(DIR_HALF))
             >>> TRIG_FRAC_BITS;
        n_rb = (RSUM_WIDTH'(r2_sa) + RSUM_WIDTH'(r2_cb) + RSUM_WIDTH'(DIR_HALF))
             >>> TRIG_FRAC_BITS;
        n_bus            = r2_bus;
        n_bus.dir[w_ia]  = DIR_WIDTH'(n_ra);
        n_bus.dir[w_ib]  = DIR_WIDTH'(n_rb);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_s   <= SC_WIDTH'(n_ms);
            r1_c   <= SC_WIDTH'(n_mc);
            r1_bus <= i_bus;
            r2_ca  <= n_ca;
            r2_sb  <= n_sb;
            r2_sa  <= n_sa;
            r2_cb  <= n_cb;
            r2_bus <= r1_bus;
            r3_bus <= n_bus;
        end
    end

    assign o_bus = r3_bus;

endmodule

// ===== rtl/core/gtp_scale.sv =====
// scale the unit direction by range, add origin, clip each coordinate
module gtp_scale import gtp_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [2:0][DIR_WIDTH-1:0]     i_dir,
    input  logic [DIST_WIDTH-1:0]         i_dist,
    input  logic [2:0][COORD_WIDTH-1:0]   i_org,
    output logic [2:0][COORD_WIDTH-1:0]   o_target,
    output logic                          o_sat
);

    logic [2:0][MUL_WIDTH-1:0]      n_prod, r_prod;
    logic [2:0]                     n_neg, r_neg;
    logic [2:0][COORD_WIDTH-1:0]    r_org;
    logic [2:0][COORD_WIDTH-1:0]    n_target;
    logic [2:0]                     n_clip;
    logic signed [DIR_WIDTH-1:0]    w_d [3];
    logic [DIR_WIDTH-1:0]           w_ad [3];
    logic [MUL_WIDTH:0]             w_mag [3];
    logic signed [OSUM_WIDTH-1:0]   w_off [3];
    logic signed [OSUM_WIDTH-1:0]   w_sum [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i]    = $signed(i_dir[i]);
            n_neg[i]  = w_d[i] < 0;
            w_ad[i]   = n_neg[i] ? DIR_WIDTH'(-w_d[i]) : DIR_WIDTH'(w_d[i]);
            n_prod[i] = {DIST_WIDTH'(0), w_ad[i]} * {DIR_WIDTH'(0), i_dist};
        end
    end

    // round half away from zero, then add origin and clip
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = ({1'b0, r_prod[i]} + (MUL_WIDTH+1)'(DIR_HALF)) >> TRIG_FRAC_BITS;
            w_off[i] = $signed(OSUM_WIDTH'(w_mag[i]));
            if (r_neg[i]) begin
                w_off[i] = -w_off[i];
            end
            w_sum[i] = OSUM_WIDTH'($signed(r_org[i])) + w_off[i];
            if (w_sum[i] > OSUM_WIDTH'(COORD_MAX)) begin
                n_target[i] = COORD_WIDTH'(COORD_MAX);
                n_clip[i]   = 1'b1;
            end else if (w_sum[i] < OSUM_WIDTH'(COORD_MIN)) begin
                n_target[i] = COORD_WIDTH'(COORD_MIN);
                n_clip[i]   = 1'b1;
            end else begin
                n_target[i] = COORD_WIDTH'(w_sum[i]);
                n_clip[i]   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= n_prod;
            r_neg    <= n_neg;
            r_org    <= i_org;
            o_target <= n_target;
            o_sat    <= |n_clip;
        end
    end

endmodule

// ===== rtl/core/gimbal_target_point_core.sv =====
// top level of the gimbal target point core: angle prep, taylor cells, rotation cells, scaling
//
// usage
//   slave stream carries one aiming request per transfer: range, origin and five
//   angles (body roll, pitch, yaw, camera pitch, yaw) packed in i_s_tdata.
//   master stream returns the target point for each request in o_m_tdata and
//   a clip flag in o_m_tuser, one result per request, in order.
//
// pipeline and throughput
//   an input transfer reaches the master side through angle prep, 5 taylor
//   cells, 5 rotation cells and scaling into the output register. one
//   request is taken every cycle unless the output stalls; all five angles
//   run in parallel lanes of taylor cells, and the rotation cells form a
//   single chain.
//
// reset and stall
//   reset clears the valid pipeline only; no result is pending after it.
//   when a result sits in the output register and the receiver does not take
//   it, the whole pipeline holds and o_s_tready drops; it rises again in the
//   cycle the receiver takes the result.
module gimbal_target_point_core import gtp_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // distance, origin_x, origin_y, origin_z, body_roll, body_pitch, body_yaw,
    // camera_pitch, camera_yaw, zero pad
    input  logic [IN_TDATA_WIDTH-1:0]   i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // target_x, target_y, target_z
    output logic [OUT_TDATA_WIDTH-1:0]  o_m_tdata,
    // saturated
    output logic                        o_m_tuser
);

    logic                              w_en;
    logic [TOTAL_LAT-1:0]              r_vld;
    logic signed [ANGLE_WIDTH-1:0]     w_ang [NUM_ANGLES];
    t_tay                              w_tay [NUM_ANGLES][TAY_STEPS+1];
    t_rot_bus                          w_bus [NUM_ANGLES+1];
    t_pass                             w_pass_in;
    t_pass                             r_pass [PASS_DEPTH];
    logic [2:0][COORD_WIDTH-1:0]       w_target;
    logic                              w_sat;

    // global advance: the output register is free or being drained
    assign w_en       = !r_vld[TOTAL_LAT-1] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[TOTAL_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], i_s_tvalid};
        end
    end

    // lanes in the order the rotations are applied
    assign w_ang[LANE_CAM_PITCH]  = $signed(i_s_tdata[OFS_CPITCH +: ANGLE_WIDTH]);
    assign w_ang[LANE_CAM_YAW]    = $signed(i_s_tdata[OFS_CYAW +: ANGLE_WIDTH]);
    assign w_ang[LANE_BODY_ROLL]  = $signed(i_s_tdata[OFS_ROLL +: ANGLE_WIDTH]);
    assign w_ang[LANE_BODY_PITCH] = $signed(i_s_tdata[OFS_PITCH +: ANGLE_WIDTH]);
    assign w_ang[LANE_BODY_YAW]   = $signed(i_s_tdata[OFS_YAW +: ANGLE_WIDTH]);

    // sine and cosine lanes
    for (genvar l = 0; l < NUM_ANGLES; l++) begin : g_lane
        gtp_angle_prep u_prep (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_angle (w_ang[l]),
            .o_tay   (w_tay[l][0])
        );
        for (genvar k = 0; k < TAY_STEPS; k++) begin : g_step
            gtp_tay_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_step (3'(k + 1)),
                .i_tay  (w_tay[l][k]),
                .o_tay  (w_tay[l][k+1])
            );
        end
        assign w_bus[0].lane[l].s    = w_tay[l][TAY_STEPS].s;
        assign w_bus[0].lane[l].c    = w_tay[l][TAY_STEPS].c;
        assign w_bus[0].lane[l].quad = w_tay[l][TAY_STEPS].quad;
        assign w_bus[0].lane[l].swap = w_tay[l][TAY_STEPS].swap;
    end

    // direction starts on the camera forward axis
    assign w_bus[0].dir[AXIS_X] = DIR_WIDTH'(DIR_ONE);
    assign w_bus[0].dir[AXIS_Y] = '0;
    assign w_bus[0].dir[AXIS_Z] = '0;

    for (genvar r = 0; r < NUM_ANGLES; r++) begin : g_rot
        gtp_rot_cell u_rot (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_lane (3'(r)),
            .i_bus  (w_bus[r]),
            .o_bus  (w_bus[r+1])
        );
    end

    // range and origin ride alongside the trig and rotation pipeline
    always_comb begin
        w_pass_in.rng = i_s_tdata[OFS_DIST +: DIST_WIDTH];
        for (int i = 0; i < 3; i++) begin
            w_pass_in.org[i] = i_s_tdata[OFS_ORG + i*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pass[0] <= w_pass_in;
            for (int i = 1; i < PASS_DEPTH; i++) begin
                r_pass[i] <= r_pass[i-1];
            end
        end
    end

    gtp_scale u_scale (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_dir    (w_bus[NUM_ANGLES].dir),
        .i_dist   (r_pass[PASS_DEPTH-1].rng),
        .i_org    (r_pass[PASS_DEPTH-1].org),
        .o_target (w_target),
        .o_sat    (w_sat)
    );

    assign o_m_tdata = OUT_TDATA_WIDTH'(w_target);
    assign o_m_tuser = w_sat;

endmodule

// ===== test/tb.sv =====
// testbench for the gimbal target point core: directed table plus random aiming requests
`timescale 1ns / 1ps
module tb;
    import gtp_pkg::*;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_s_tvalid;
    logic                        o_s_tready;
    logic [IN_TDATA_WIDTH-1:0]   i_s_tdata;
    logic                        o_m_tvalid;
    logic                        i_m_tready;
    logic [OUT_TDATA_WIDTH-1:0]  o_m_tdata;
    logic                        o_m_tuser;

    typedef struct {
        logic [DIST_WIDTH-1:0]          rng;
        logic signed [COORD_WIDTH-1:0]  org [3];
        logic signed [ANGLE_WIDTH-1:0]  ang [5];  // roll, pitch, yaw, cam pitch, cam yaw
    } aim_t;

    typedef struct {
        logic signed [COORD_WIDTH-1:0]  tgt [3];
        logic                           sat;
    } point_t;

    localparam int N_DIRECTED = 12;
    localparam int N_RANDOM   = 1900;
    localparam int DMAX       = (1 << 30) - 1 + (1 << 30);

    point_t  pending_points [$];
    int      error_count;
    int      stall_left;
    bit      calm;
    logic    send_valid;
    bit      directed_has [N_DIRECTED];
    point_t  directed_pt  [N_DIRECTED];
    aim_t    directed_aim [N_DIRECTED];

    gimbal_target_point_core dut (.*);

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    initial begin
        #50ms;
        $display("FAIL gimbal_target_point_core");
        $finish;
    end

    function automatic longint rshift_round(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    // taylor sine/cosine of the base angle, Q30
    function automatic void base_sincos(longint t, output longint s, output longint c);
        longint unsigned x, x2, term;
        x  = (longint'(t) * 64'd299845282 + 64'd512) >> 10;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        s = x;
        for (int k = 1; k <= 4; k++) begin
            term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
            s += (k & 1) ? -longint'(term) : longint'(term);
        end
        term = 64'd1 << 30;
        c = longint'(1) << 30;
        for (int k = 1; k <= 5; k++) begin
            term = ((term * x2) >> 30) / ((2 * k - 1) * (2 * k));
            c += (k & 1) ? -longint'(term) : longint'(term);
        end
    endfunction

    function automatic void angle_sincos(longint a, output longint s, output longint c);
        longint m, q, f, s0, c0;
        m = a % FULL_TURN;
        if (m < 0) m += FULL_TURN;
        q = m / QUARTER_TURN;
        f = m % QUARTER_TURN;
        if (f <= EIGHTH_TURN) base_sincos(f, s0, c0);
        else base_sincos(QUARTER_TURN - f, c0, s0);
        case (q)
            0:       begin s = s0;  c = c0;  end
            1:       begin s = c0;  c = -s0; end
            2:       begin s = -s0; c = -c0; end
            default: begin s = -c0; c = s0;  end
        endcase
        s = rshift_round(s, 30 - TRIG_FRAC_BITS);
        c = rshift_round(c, 30 - TRIG_FRAC_BITS);
    endfunction

    function automatic void turn_pair(ref longint a, ref longint b, input longint ang);
        longint s, c, na, nb;
        angle_sincos(ang, s, c);
        na = rshift_round(c * a - s * b, TRIG_FRAC_BITS);
        nb = rshift_round(s * a + c * b, TRIG_FRAC_BITS);
        a = na;
        b = nb;
    endfunction

    function automatic longint range_offset(longint d, longint rng);
        longint unsigned ad, mag;
        ad  = (d < 0) ? longint'(-d) : longint'(d);
        // range < 2^31 and |d| <= 2^19 so the product fits
        mag = (ad * longint'(rng) + (64'd1 << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
        if (mag > (64'd1 << 62)) mag = 64'd1 << 62;
        return (d < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic point_t target_point(aim_t r);
        point_t  p;
        longint  dir [3];
        longint  v;
        dir[0] = longint'(1) << TRIG_FRAC_BITS;
        dir[1] = 0;
        dir[2] = 0;
        turn_pair(dir[2], dir[0], r.ang[3]);
        turn_pair(dir[0], dir[1], r.ang[4]);
        turn_pair(dir[1], dir[2], r.ang[0]);
        turn_pair(dir[2], dir[0], r.ang[1]);
        turn_pair(dir[0], dir[1], r.ang[2]);
        p.sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            v = longint'(r.org[i]) + range_offset(dir[i], r.rng);
            if (v > COORD_MAX) begin v = COORD_MAX; p.sat = 1'b1; end
            if (v < COORD_MIN) begin v = COORD_MIN; p.sat = 1'b1; end
            p.tgt[i] = v[COORD_WIDTH-1:0];
        end
        return p;
    endfunction

    function automatic logic [IN_TDATA_WIDTH-1:0] pack_aim(aim_t r);
        logic [IN_TDATA_WIDTH-1:0] w;
        w = '0;
        w[OFS_DIST +: DIST_WIDTH] = r.rng;
        for (int i = 0; i < 3; i++) w[OFS_ORG + i * COORD_WIDTH +: COORD_WIDTH] = r.org[i];
        for (int i = 0; i < 5; i++) w[OFS_ROLL + i * ANGLE_WIDTH +: ANGLE_WIDTH] = r.ang[i];
        return w;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // random angle, mostly in range, sometimes any 16-bit pattern
    function automatic logic [ANGLE_WIDTH-1:0] rand_angle();
        if ($urandom_range(0, 7) == 0) return ANGLE_WIDTH'($urandom);
        return ANGLE_WIDTH'($urandom_range(0, 2 * FULL_TURN) - FULL_TURN);
    endfunction

    function automatic aim_t rand_aim();
        aim_t r;
        case ($urandom_range(0, 3))
            0:       r.rng = DIST_WIDTH'($urandom);
            1:       r.rng = DIST_WIDTH'($urandom_range(0, 1 << 24));
            2:       r.rng = DIST_WIDTH'(DMAX - $urandom_range(0, 255));
            default: r.rng = DIST_WIDTH'($urandom_range(0, 1 << 20));
        endcase
        for (int i = 0; i < 3; i++)
            r.org[i] = ($urandom_range(0, 1)) ? $urandom
                                              : $signed(32'($urandom_range(0, 1 << 24))) - (1 << 23);
        for (int i = 0; i < 5; i++) r.ang[i] = rand_angle();
        return r;
    endfunction

    task automatic send_aim(aim_t r);
        while (!calm && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pack_aim(r);
        pending_points.push_back(target_point(r));
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // receiver stall and checking
    always @(posedge i_clk) begin
        point_t want;
        logic signed [COORD_WIDTH-1:0] got;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_points.size() == 0) begin
                    $display("unexpected result transfer");
                    error_count++;
                end else begin
                    want = pending_points.pop_front();
                    for (int i = 0; i < 3; i++) begin
                        got = o_m_tdata[i * COORD_WIDTH +: COORD_WIDTH];
                        if (got !== want.tgt[i])
                            report_mismatch($sformatf("target[%0d]", i), got, want.tgt[i]);
                    end
                    if (o_m_tuser !== want.sat) report_mismatch("saturated", o_m_tuser, want.sat);
                end
            end
            // stalls come in bursts whose length is drawn at random
            if (calm) begin
                i_m_tready <= 1'b1;
                stall_left = 0;
            end else if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    function automatic aim_t mk(longint d, longint x, longint y, longint z,
                                longint r, longint p, longint w, longint cp, longint cy);
        aim_t a;
        a.rng = d; a.org[0] = x; a.org[1] = y; a.org[2] = z;
        a.ang[0] = r; a.ang[1] = p; a.ang[2] = w; a.ang[3] = cp; a.ang[4] = cy;
        return a;
    endfunction

    initial begin
        point_t pt;
        error_count = 0;
        stall_left  = 0;
        calm        = 0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        // directed table: zero, extremes, wrap, saturation
        directed_aim[0]  = mk(0, 0, 0, 0, 0, 0, 0, 0, 0);
        directed_aim[1]  = mk(65536, 0, 0, 0, 0, 0, 0, 0, 0);
        directed_aim[2]  = mk(DMAX, COORD_MAX, 0, 0, 0, 0, 0, 0, 0);
        directed_aim[3]  = mk(DMAX, COORD_MIN, 0, 0, 0, 0, 0, 0, HALF_TURN);
        directed_aim[4]  = mk(0, COORD_MIN, COORD_MAX, -1, 0, 0, 0, 0, 0);
        directed_aim[5]  = mk(65536, 0, 0, 0, -FULL_TURN, FULL_TURN, -FULL_TURN, FULL_TURN, 0);
        directed_aim[6]  = mk(DMAX, 0, 0, 0, 32767, -32768, 32767, -32768, 32767);
        directed_aim[7]  = mk(1 << 20, 0, 0, 0, QUARTER_TURN, EIGHTH_TURN, THREE_QUARTER,
                              -QUARTER_TURN, EIGHTH_TURN + 1);
        directed_aim[8]  = mk(DMAX, 0, COORD_MAX, COORD_MIN, 0, 0, QUARTER_TURN,
                              -QUARTER_TURN, 0);
        directed_aim[9]  = mk(12345, -7, 99, 1 << 30, 1, -1, 2879, 2881, -5759);
        directed_aim[10] = mk(DMAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 0, 0);
        directed_aim[11] = mk(DMAX, COORD_MIN, COORD_MIN, COORD_MIN, 0, HALF_TURN, 0, 0, 0);
        directed_has = '{default: 0};
        // at zero range the origin comes straight through
        directed_has[0] = 1;
        directed_pt[0].tgt = '{0, 0, 0}; directed_pt[0].sat = 0;
        directed_has[4] = 1;
        directed_pt[4].tgt = '{COORD_MIN, COORD_MAX, -1}; directed_pt[4].sat = 0;
        // forward axis unturned: one metre along x
        directed_has[1] = 1;
        directed_pt[1].tgt = '{65536, 0, 0}; directed_pt[1].sat = 0;
        directed_has[2] = 1;
        directed_pt[2].tgt = '{COORD_MAX, 0, 0}; directed_pt[2].sat = 1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int n = 0; n < N_DIRECTED; n++) begin
            pt = target_point(directed_aim[n]);
            if (directed_has[n] && (pt.tgt != directed_pt[n].tgt || pt.sat != directed_pt[n].sat))
                report_mismatch($sformatf("table row %0d", n), 0, 0);
            send_aim(directed_aim[n]);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 200) calm = 1;
            send_aim(rand_aim());
        end
        i_s_tvalid <= 1'b0;
        calm = 1;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (TOTAL_LAT + 10) @(posedge i_clk);
        if (error_count == 0) $display("PASS gimbal_target_point_core");
        else $display("FAIL gimbal_target_point_core");
        $finish;
    end

endmodule
